/* rtl/ilsrv_pkg.sv */
`default_nettype none
package ilsrv_pkg;

  // List geometry.
  localparam int CAPACITY   = 64;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Fixed port field widths.
  localparam int CMD_BITS  = 2;
  localparam int VAL_BITS  = 32;
  localparam int POS_BITS  = 6;
  localparam int STAT_BITS = 2;
  localparam int RDW_BITS  = 32;
  localparam int FILL_BITS = 7;

  // Width for comparing a requested position against the fill count.
  localparam int CMP_BITS = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS + 1;

  // Command codes.
  localparam logic [CMD_BITS-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat
    logic exec;       // carry out the command's first step
    logic take_read;  // capture the word read from the store
    logic scan;       // one step of the compaction walk
    logic publish;    // load the result into the output register
  } ilsrv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_ok;    // read command with a position inside the list
    logic is_remove;  // remove command latched
    logic scan_done;  // compaction walk finished
    logic out_free;   // output register can take a result this cycle
  } ilsrv_sts_t;

endpackage
`default_nettype wire

/* rtl/ilsrv_ram.sv */
`default_nettype none
module ilsrv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/ilsrv_ctrl.sv */
`default_nettype none
module ilsrv_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ilsrv_pkg::ilsrv_sts_t sts,
  output ilsrv_pkg::ilsrv_cmd_t     ctrl
);
  import ilsrv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDATA  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next        = state;
    ctrl              = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        if (sts.read_ok) begin
          state_next = S_RDATA;
        end else if (sts.is_remove) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_RDATA: begin
        ctrl.take_read = 1'b1;
        state_next     = S_FINISH;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctrl.publish = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ilsrv_dp.sv */
`default_nettype none
module ilsrv_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ilsrv_pkg::ilsrv_cmd_t                  ctrl,
  output ilsrv_pkg::ilsrv_sts_t                       sts,
  input  wire logic        [ilsrv_pkg::CMD_BITS-1:0]  command,
  input  wire logic signed [ilsrv_pkg::VAL_BITS-1:0]  value,
  input  wire logic        [ilsrv_pkg::POS_BITS-1:0]  position,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [ilsrv_pkg::STAT_BITS-1:0] status,
  output logic signed      [ilsrv_pkg::RDW_BITS-1:0]  read_word,
  output logic             [ilsrv_pkg::FILL_BITS-1:0] fill_level
);
  import ilsrv_pkg::*;

  // Latched command beat.
  logic [CMD_BITS-1:0] cmd_q;
  word_t               val_q;
  logic [POS_BITS-1:0] pos_q;

  // List state and compaction walk.
  count_t fill;
  count_t idx;
  count_t kept;
  logic   pend;

  // Result being built.
  logic [STAT_BITS-1:0] res_status;
  logic [RDW_BITS-1:0]  res_word;

  // Store port signals.
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  word_t                wdata;
  logic [ADDR_BITS-1:0] raddr;
  word_t                rdata;

  logic full;
  logic pos_ok;
  logic scan_more;
  logic keep;

  ilsrv_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Conditions on the list.
  assign full      = (fill == COUNT_BITS'(CAPACITY));
  assign pos_ok    = (CMP_BITS'(pos_q) < CMP_BITS'(fill));
  assign scan_more = (idx < fill);
  assign keep      = pend && (rdata != val_q);

  // Status towards the controller.
  always_comb begin
    sts.read_ok   = (cmd_q == CMD_READ) && pos_ok;
    sts.is_remove = (cmd_q == CMD_REMOVE);
    sts.scan_done = (idx == fill) && !pend;
    sts.out_free  = !out_valid || out_ready;
  end

  // Store port: append on a store, read for a read, and during the walk
  // read ahead while writing each survivor back at the compacted position.
  always_comb begin
    we    = 1'b0;
    waddr = fill[ADDR_BITS-1:0];
    wdata = val_q;
    raddr = idx[ADDR_BITS-1:0];
    if (ctrl.exec) begin
      if ((cmd_q == CMD_STORE) && !full) begin
        we = 1'b1;
      end
      if (cmd_q == CMD_READ) begin
        raddr = ADDR_BITS'(pos_q);
      end
    end
    if (ctrl.scan) begin
      we    = keep;
      waddr = kept[ADDR_BITS-1:0];
      wdata = rdata;
    end
  end

  // Command beat and result payload.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= command;
      val_q <= WORD_BITS'(value);
      pos_q <= position;
    end
    if (ctrl.exec) begin
      res_word <= '0;
      idx      <= '0;
      kept     <= '0;
      case (cmd_q)
        CMD_STORE: res_status <= full ? ST_FULL : ST_OK;
        CMD_READ:  res_status <= pos_ok ? ST_OK : ST_RANGE;
        default:   res_status <= ST_OK;
      endcase
    end
    if (ctrl.take_read) begin
      res_word <= RDW_BITS'(rdata);
    end
    if (ctrl.scan) begin
      if (scan_more) begin
        idx <= idx + COUNT_BITS'(1);
      end
      if (keep) begin
        kept <= kept + COUNT_BITS'(1);
      end
    end
    if (ctrl.publish) begin
      status     <= res_status;
      read_word  <= res_word;
      fill_level <= FILL_BITS'(fill);
    end
  end

  // Fill count, walk pipeline flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        pend <= 1'b0;
        if ((cmd_q == CMD_STORE) && !full) begin
          fill <= fill + COUNT_BITS'(1);
        end
      end
      if (ctrl.scan) begin
        pend <= scan_more;
        if (sts.scan_done) begin
          fill <= kept;
        end
      end
      if (ctrl.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The list never holds more entries than the store has.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= COUNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  // Survivors are never written ahead of the read pointer.
  a_kept_behind: assert property (@(posedge clk) disable iff (rst)
    ctrl.scan |-> (kept <= idx))
    else $error("compaction write pointer passed read pointer");

  // A store into a list with room grows it by exactly one entry.
  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.exec && (cmd_q == CMD_STORE) && !full) |=>
      (fill == $past(fill) + COUNT_BITS'(1)))
    else $error("store did not grow the list by one");

endmodule
`default_nettype wire

/* rtl/int_list_store_read_remove_value_top.sv */
// A store or unused command goes from S_EXEC to S_FINISH, a read within the list through S_EXEC,
// S_RDATA and S_FINISH, and a remove through S_EXEC, S_SCAN and S_FINISH; the remove walk reads
// and rewrites one entry per cycle through the store's read and write ports.
// Throughput: one command in flight; the next beat is accepted the cycle after the result is
// loaded into the output register, while that result may still wait to be taken.
// Reset clears the fill count and handshake state; the entry store itself is not cleared.
`default_nettype none
module int_list_store_read_remove_value_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic        [ilsrv_pkg::CMD_BITS-1:0]  command,
  input  wire logic signed [ilsrv_pkg::VAL_BITS-1:0]  value,
  input  wire logic        [ilsrv_pkg::POS_BITS-1:0]  position,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [ilsrv_pkg::STAT_BITS-1:0] status,
  output logic signed      [ilsrv_pkg::RDW_BITS-1:0]  read_word,
  output logic             [ilsrv_pkg::FILL_BITS-1:0] fill_level
);
  import ilsrv_pkg::*;

  ilsrv_cmd_t ctrl;
  ilsrv_sts_t sts;

  // Sequencer.
  ilsrv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  // List store, walk counters and result register.
  ilsrv_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sts        (sts),
    .command    (command),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_word  (read_word),
    .fill_level (fill_level)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  import ilsrv_pkg::*;

  // The unused command code has no name in the package.
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [RDW_BITS-1:0]  word;
    logic [FILL_BITS-1:0] fill;
  } list_result_t;

  // Shadow copy of the list: applies each accepted command and queues the result it
  // must produce, then compares the block's result beats against that queue in order.
  class list_shadow;
    logic [WORD_BITS-1:0] words[CAPACITY];
    int count;
    int failures;
    list_result_t awaited[$];

    function new();
      count = 0;
      failures = 0;
    endfunction

    function void note_command(logic [CMD_BITS-1:0] cmd, logic [VAL_BITS-1:0] val,
                               logic [POS_BITS-1:0] pos);
      list_result_t r;
      int kept;
      r.status = ST_OK;
      r.word = '0;
      case (cmd)
        CMD_STORE: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            words[count] = val;
            count++;
          end
        end
        CMD_READ: begin
          if (int'(pos) >= count) begin
            r.status = ST_RANGE;
          end else begin
            r.word = words[pos];
          end
        end
        CMD_REMOVE: begin
          // Keep the survivors in their original order.
          kept = 0;
          for (int i = 0; i < count; i++) begin
            if (words[i] != val) begin
              words[kept] = words[i];
              kept++;
            end
          end
          count = kept;
        end
        default: ;
      endcase
      r.fill = count[FILL_BITS-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STAT_BITS-1:0] st, logic [RDW_BITS-1:0] rd,
                               logic [FILL_BITS-1:0] fl);
      list_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited: status=%0d read_word=%h fill_level=%0d",
                 $time, st, rd, fl);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, st);
        failures++;
      end
      if (rd !== want.word) begin
        $display("%0t: read_word expected %h, got %h", $time, want.word, rd);
        failures++;
      end
      if (fl !== want.fill) begin
        $display("%0t: fill_level expected %0d, got %0d", $time, want.fill, fl);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_BITS-1:0] command = CMD_STORE;
  logic signed [VAL_BITS-1:0] value = '0;
  logic [POS_BITS-1:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_BITS-1:0] status;
  logic signed [RDW_BITS-1:0] read_word;
  logic [FILL_BITS-1:0] fill_level;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic [VAL_BITS-1:0] word_pool[16];
  list_shadow sb = new();

  int_list_store_read_remove_value_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .read_word(read_word),
    .fill_level(fill_level)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random back-pressure, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result beat taken is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(status, read_word, fill_level);
    end
  end

  // Offers one command beat, with random gaps first, and notes it once accepted.
  // Entered and left just after a falling edge.
  task automatic offer(input logic [CMD_BITS-1:0] cmd, input logic [VAL_BITS-1:0] val,
                       input logic [POS_BITS-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= val;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(cmd, val, pos);
    @(negedge clk);
  endtask

  // Half of the words are drawn from a small pool of 16 so that duplicates build up.
  function automatic logic [VAL_BITS-1:0] pick_word();
    case ($urandom_range(3))
      0, 1: pick_word = word_pool[$urandom_range(15)];
      2: pick_word = $urandom;
      default: begin
        case ($urandom_range(3))
          0: pick_word = 32'h8000_0000;
          1: pick_word = 32'h7fff_ffff;
          2: pick_word = 32'h0000_0000;
          default: pick_word = 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // A random command, weighted towards filling the list in a fill-heavy stretch.
  task automatic random_command(input bit fill_heavy);
    int roll;
    int r;
    logic [POS_BITS-1:0] pos;
    logic [VAL_BITS-1:0] val;
    roll = $urandom_range(99);
    if (fill_heavy ? roll < 85 : roll < 45) begin
      offer(CMD_STORE, pick_word(), POS_BITS'($urandom));
    end else if (fill_heavy ? roll < 93 : roll < 75) begin
      r = $urandom_range(9);
      if (sb.count > 0 && r < 6) begin
        pos = POS_BITS'($urandom_range(sb.count - 1));
      end else if (sb.count < CAPACITY && r < 8) begin
        pos = POS_BITS'(sb.count);
      end else begin
        pos = POS_BITS'($urandom_range(CAPACITY - 1));
      end
      offer(CMD_READ, $urandom, pos);
    end else if (fill_heavy ? roll < 98 : roll < 95) begin
      if (sb.count > 0 && $urandom_range(9) < 7) begin
        val = sb.words[$urandom_range(sb.count - 1)];
      end else begin
        val = pick_word();
      end
      offer(CMD_REMOVE, val, POS_BITS'($urandom));
    end else begin
      offer(CMD_UNUSED, $urandom, POS_BITS'($urandom));
    end
  endtask

  // One random phase; the long receiver hold-off is raised part way through if asked.
  task automatic random_phase(input int items, input int send_pct, input int recv_pct,
                              input bit with_hold);
    bit fill_heavy;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    fill_heavy = 1'b0;
    for (int n = 0; n < items; n++) begin
      if (n % 100 == 0) fill_heavy = ($urandom_range(2) == 0);
      if (with_hold && n == 100) hold_left = 500;
      random_command(fill_heavy);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) word_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, extreme words, range edges, duplicate removal.
    send_idle_pct = 37;
    recv_idle_pct = 69;
    offer(CMD_READ, 32'h0, 6'd0);
    offer(CMD_REMOVE, 32'd5, 6'd0);
    offer(CMD_UNUSED, 32'h0, 6'd0);
    offer(CMD_STORE, 32'h8000_0000, 6'd63);
    offer(CMD_STORE, 32'h7fff_ffff, 6'd0);
    offer(CMD_STORE, 32'h0000_0000, 6'd0);
    offer(CMD_STORE, 32'hffff_ffff, 6'd0);
    offer(CMD_STORE, 32'hffff_ffff, 6'd0);
    offer(CMD_STORE, 32'h8000_0000, 6'd0);
    offer(CMD_READ, 32'hffff_ffff, 6'd0);
    offer(CMD_READ, 32'h0, 6'd5);
    offer(CMD_READ, 32'h0, 6'd6);
    offer(CMD_READ, 32'h0, 6'd63);
    offer(CMD_REMOVE, 32'd12345, 6'd0);
    offer(CMD_REMOVE, 32'hffff_ffff, 6'd0);
    offer(CMD_READ, 32'h0, 6'd3);
    offer(CMD_REMOVE, 32'h8000_0000, 6'd0);
    offer(CMD_UNUSED, 32'hffff_ffff, 6'd63);
    offer(CMD_REMOVE, 32'h7fff_ffff, 6'd0);
    offer(CMD_REMOVE, 32'h0, 6'd63);
    offer(CMD_READ, 32'h0, 6'd0);
    offer(CMD_STORE, 32'h5a5a_5a5a, 6'd0);
    offer(CMD_READ, 32'h0, 6'd0);

    // Random: three idling patterns, the last with a long receiver hold-off.
    random_phase(500, 37, 69, 1'b0);
    random_phase(500, 69, 37, 1'b0);
    random_phase(500, 0, 0, 1'b1);
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* int_list_store_read_remove_value_top.f */
rtl/ilsrv_pkg.sv
rtl/ilsrv_ram.sv
rtl/ilsrv_ctrl.sv
rtl/ilsrv_dp.sv
rtl/int_list_store_read_remove_value_top.sv
tb/testbench.sv
